[rtl/core/lrsi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsi_pkg
// Shared constants for the linear ranking selection index block.
// ----------------------------------------------------------------------------
package lrsi_pkg;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 18;
  localparam int ETA_BITS       = 18;
  localparam int DIFF_BITS      = 17;
  localparam int POP_BITS       = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_EXPECTED    = 1'b0,
    REG_POPULATION_SIZE = 1'b1
  } cfg_reg_t;

  localparam logic [ETA_BITS-1:0] ETA_ONE        = 18'd65536;
  localparam logic [ETA_BITS-1:0] ETA_TWO        = 18'd131072;
  localparam logic [ETA_BITS-1:0] ETA_RESET      = 18'd98304;
  localparam logic [POP_BITS-1:0] POP_SIZE_RESET = 16'd64;

endpackage

[rtl/core/lrsi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsi_if
// Handshake channels: random sample in, index out, configuration writes.
// ----------------------------------------------------------------------------
interface lrsi_sample_if #(parameter int RANDOM_BITS = 32);
  logic                   valid;
  logic                   ready;
  logic [RANDOM_BITS-1:0] random_fraction;
  modport source (output valid, output random_fraction, input ready);
  modport sink   (input valid, input random_fraction, output ready);
endinterface

interface lrsi_result_if #(parameter int INDEX_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] selected_index;
  modport source (output valid, output selected_index, input ready);
  modport sink   (input valid, input selected_index, output ready);
endinterface

interface lrsi_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lrsi_pkg::CFG_INDEX_BITS-1:0] index;
  logic [lrsi_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/linear_rank_selection_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_rank_selection_index
// Linear ranking selection: maps a uniform fraction u to a parent rank index,
// the largest k < P with k/P*(eta - (eta-1)*k/P) <= u, by a pipelined
// bitwise search with exact integer compares.
// ----------------------------------------------------------------------------
//
// channel  | dir | payload                          | transfer when
// ---------+-----+----------------------------------+------------------
// sample   | in  | random_fraction [RANDOM_BITS]    | valid & ready
// result   | out | selected_index  [INDEX_BITS]     | valid & ready
// cfg      | in  | index [1], data [18]             | valid (ready = 1)
//
// One transfer per cycle in each direction while the result side accepts. The
// pipeline has 4 + 3*INDEX_BITS stages: four set-up (clamp, products, split
// u*P^2, sum) and three per index bit (d*k, k*(eP - dk), compare and keep).
// Each stage holds while its successor is full and stalled; bubbles close up,
// so nothing is dropped or repeated.
// Synchronous active-high reset clears the valid bits and loads the register
// reset values (eta 1.5, P 64). Payload registers are not reset.
// ----------------------------------------------------------------------------
module linear_rank_selection_index #(
  parameter int INDEX_BITS  = 16,
  parameter int RANDOM_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  lrsi_sample_if.sink   sample,
  lrsi_result_if.source result,
  lrsi_cfg_if.sink      cfg
);

  localparam int IB   = INDEX_BITS;
  localparam int RB   = RANDOM_BITS;
  localparam int EW   = lrsi_pkg::ETA_BITS;
  localparam int DW   = lrsi_pkg::DIFF_BITS;
  localparam int PW   = lrsi_pkg::POP_BITS;
  localparam int EPW  = EW + PW;                 // eta * P
  localparam int PPW  = 2 * PW;                  // P^2
  localparam int H    = (RB + 1) / 2;            // split of u for u*P^2
  localparam int LOW  = H + PPW;
  localparam int HIW  = RB - H + PPW;
  localparam int RHW  = RB + PPW;                // u * P^2
  localparam int DKW  = DW + IB;
  localparam int PRW  = IB + EPW;
  localparam int LHW  = PRW + RB - 16;
  localparam int CMW  = (LHW > RHW) ? LHW : RHW;
  localparam int LIMW = (IB > PW) ? IB : PW;
  localparam int NST  = 4 + 3 * IB;              // pipeline stages

  // configuration registers
  logic [EW-1:0] max_expected;
  logic [PW-1:0] population_size;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_expected    <= lrsi_pkg::ETA_RESET;
      population_size <= lrsi_pkg::POP_SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        lrsi_pkg::REG_MAX_EXPECTED:    max_expected    <= cfg.data;
        lrsi_pkg::REG_POPULATION_SIZE: population_size <= cfg.data[PW-1:0];
        default: ;
      endcase
    end
  end

  // stage registers; each stage uses only some of the fields
  logic           vld   [NST];
  logic           rdy   [NST+1];
  logic [RB-1:0]  u     [NST];
  logic [EW-1:0]  eta   [NST];
  logic [DW-1:0]  d     [NST];
  logic [PW-1:0]  p     [NST];
  logic [EPW-1:0] ep    [NST];
  logic [PPW-1:0] pp    [NST];
  logic [LOW-1:0] plo   [NST];
  logic [HIW-1:0] phi   [NST];
  logic [RHW-1:0] rhs   [NST];
  logic [IB-1:0]  limit [NST];
  logic           pz    [NST];
  logic [IB-1:0]  res   [NST];
  logic [DKW-1:0] dk    [NST];
  logic [PRW-1:0] prod  [NST];

  assign rdy[NST] = result.ready;

  genvar s;
  for (s = 0; s < NST; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end

  assign sample.ready = rdy[0];

  // stage 0: capture u, clamp eta to [1, 2]
  logic [EW-1:0] eta_clamped;
  always_comb begin
    if (max_expected < lrsi_pkg::ETA_ONE) begin
      eta_clamped = lrsi_pkg::ETA_ONE;
    end else if (max_expected > lrsi_pkg::ETA_TWO) begin
      eta_clamped = lrsi_pkg::ETA_TWO;
    end else begin
      eta_clamped = max_expected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      u[0]     <= sample.random_fraction;
      eta[0]   <= eta_clamped;
      d[0]     <= DW'(eta_clamped - lrsi_pkg::ETA_ONE);
      p[0]     <= population_size;
      ep[0]    <= '0;
      pp[0]    <= '0;
      plo[0]   <= '0;
      phi[0]   <= '0;
      rhs[0]   <= '0;
      limit[0] <= '0;
      pz[0]    <= 1'b0;
      res[0]   <= '0;
      dk[0]    <= '0;
      prod[0]  <= '0;
    end
  end

  // stages 1 .. NST-1
  for (s = 1; s < NST; s++) begin : g_stage
    localparam int J   = (s >= 4) ? (s - 4) / 3 : 0;
    localparam int SUB = (s >= 4) ? (s - 4) % 3 : 0;
    localparam int BIT = IB - 1 - J;

    logic [IB-1:0]   cand;
    logic [LIMW-1:0] pm1;
    logic [IB-1:0]   lim_top;
    logic [EPW-1:0]  t;
    logic [CMW-1:0]  lhs_ext;
    logic [CMW-1:0]  rhs_ext;
    logic            keep;

    always_comb begin
      cand    = res[s-1] | (IB'(1) << BIT);
      pm1     = LIMW'(p[s-1] - PW'(1));
      // index ceiling: P-1, capped at the index width
      lim_top = (pm1 > LIMW'({IB{1'b1}})) ? '1 : IB'(pm1);
      t       = ep[s-1] - EPW'(dk[s-1]);
      lhs_ext = CMW'(prod[s-1]) << (RB - 16);
      rhs_ext = CMW'(rhs[s-1]);
      // keep the bit when k stays in range and f(k/P) <= u
      keep    = !pz[s-1] && (cand <= limit[s-1]) && (lhs_ext <= rhs_ext);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        u[s]     <= u[s-1];
        eta[s]   <= eta[s-1];
        d[s]     <= d[s-1];
        p[s]     <= p[s-1];
        // stage 1: eta*P, P^2 and the index ceiling
        ep[s]    <= (s == 1) ? EPW'(eta[s-1]) * EPW'(p[s-1]) : ep[s-1];
        pp[s]    <= (s == 1) ? PPW'(p[s-1]) * PPW'(p[s-1]) : pp[s-1];
        pz[s]    <= (s == 1) ? (p[s-1] == '0) : pz[s-1];
        limit[s] <= (s == 1) ? lim_top : limit[s-1];
        // stage 2: u*P^2 in two halves; stage 3: their sum
        plo[s]   <= (s == 2) ? LOW'(u[s-1][H-1:0]) * LOW'(pp[s-1]) : plo[s-1];
        phi[s]   <= (s == 2) ? HIW'(u[s-1][RB-1:H]) * HIW'(pp[s-1]) : phi[s-1];
        rhs[s]   <= (s == 3) ? RHW'(plo[s-1]) + (RHW'(phi[s-1]) << H) : rhs[s-1];
        dk[s]    <= (s >= 4 && SUB == 0) ? DKW'(d[s-1]) * DKW'(cand) : dk[s-1];
        prod[s]  <= (s >= 4 && SUB == 1) ? PRW'(cand) * PRW'(t) : prod[s-1];
        if (s == 1) begin
          res[s] <= '0;
        end else if (s >= 4 && SUB == 2 && keep) begin
          res[s] <= cand;
        end else begin
          res[s] <= res[s-1];
        end
      end
    end
  end

  assign result.valid          = vld[NST-1];
  assign result.selected_index = res[NST-1];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && !pz[NST-1]) |-> (res[NST-1] <= limit[NST-1]))
    else $error("selected index beyond population limit");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && pz[NST-1]) |-> (res[NST-1] == '0))
    else $error("empty population gave nonzero index");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> vld[0])
    else $error("accepted sample did not enter pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && !result.ready) |=> (vld[NST-1] && $stable(res[NST-1])))
    else $error("stalled result lost or changed");

endmodule

[tb/tb_linear_rank_selection_index.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_rank_selection_index
// Self-checking bench for the linear ranking selection index block. A short
// table of directed steps covers the register extremes, the clamping of eta,
// an empty and a single-member population, and exact rank boundaries. A long
// random run follows over several register settings. Both handshake sides
// idle at random, and the result side holds off once for a long stretch so
// that the pipeline fills up. Every index is checked against a bit-exact
// predictor, and against a typed value where the table gives one.
// ----------------------------------------------------------------------------
module tb_linear_rank_selection_index;

  localparam int IDX_W       = 16;
  localparam int RND_W       = 32;
  localparam int LATENCY     = 4 + 3 * IDX_W;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 230;

  logic clk;
  logic rst;

  lrsi_sample_if #(.RANDOM_BITS(RND_W)) smp ();
  lrsi_result_if #(.INDEX_BITS(IDX_W))  res ();
  lrsi_cfg_if                           cfgc ();

  linear_rank_selection_index #(
    .INDEX_BITS  (IDX_W),
    .RANDOM_BITS (RND_W)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfgc)
  );

  // one pending index: predicted value plus an optional hand-typed one
  typedef struct {
    logic [IDX_W-1:0] predicted;
    bit               typed;
    logic [IDX_W-1:0] typed_index;
  } pending_index_t;

  // a directed step is either a register write or a sample
  typedef struct {
    bit                 is_write;
    lrsi_pkg::cfg_reg_t reg_sel;
    logic [17:0]        wdata;
    logic [RND_W-1:0]   frac;
    bit                 typed;
    logic [IDX_W-1:0]   want;
  } step_t;

  pending_index_t pending_q[$];

  // shadow of the block's registers, updated on each cfg transfer
  logic [lrsi_pkg::ETA_BITS-1:0] eta_shadow;
  logic [lrsi_pkg::POP_BITS-1:0] pop_shadow;

  // typed expectation for the sample currently offered
  bit               offer_typed;
  logic [IDX_W-1:0] offer_want;

  int  fail_count;
  int  index_count;
  int  write_count;
  int  cycle_count;
  bit  hold_req;
  bit  hold_done;

  // ---------------------------------------------------------------------------
  // Rank predictor: largest k <= P-1 with k*(eP - dk) * 2^16 <= u * P^2,
  // found bit by bit from the top. All sums are kept exact in 128 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] rank_index(
    logic [RND_W-1:0] u,
    logic [lrsi_pkg::ETA_BITS-1:0] eta_reg,
    logic [lrsi_pkg::POP_BITS-1:0] pop);
    logic [lrsi_pkg::ETA_BITS-1:0] eta;
    logic [IDX_W-1:0]              k;
    logic [IDX_W-1:0]              cand;
    logic [127:0]                  ew, dw, pw, cw, lhs, rhs;
    k   = '0;
    eta = eta_reg;
    if (eta < lrsi_pkg::ETA_ONE) eta = lrsi_pkg::ETA_ONE;  // eta below one acts as one
    if (eta > lrsi_pkg::ETA_TWO) eta = lrsi_pkg::ETA_TWO;  // and above two as two
    ew  = 128'(eta);
    dw  = 128'(eta - lrsi_pkg::ETA_ONE);
    pw  = 128'(pop);
    rhs = 128'(u) * pw * pw;
    if (pop != '0) begin
      for (int b = IDX_W - 1; b >= 0; b--) begin
        cand = k | (IDX_W'(1) << b);
        if (32'(cand) <= 32'(pop) - 1) begin
          cw  = 128'(cand);
          lhs = (cw * (ew * pw - dw * cw)) << (RND_W - 16);
          if (lhs <= rhs) k = cand;       // equality keeps the boundary rank
        end
      end
    end
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset and the cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d indices pending", cycle_count,
               pending_q.size());
      $display("FAIL linear_rank_selection_index");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Transfer monitor: register shadow, expectation store and result checks.
  // All reads happen at the rising edge, before the block's own updates land.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pending_index_t got_exp;
    if (!rst) begin
      if (cfgc.valid && cfgc.ready) begin
        write_count <= write_count + 1;
        if (cfgc.index == lrsi_pkg::REG_MAX_EXPECTED) eta_shadow <= cfgc.data;
        else pop_shadow <= cfgc.data[lrsi_pkg::POP_BITS-1:0];
      end
      if (smp.valid && smp.ready) begin
        got_exp.predicted   = rank_index(smp.random_fraction, eta_shadow, pop_shadow);
        got_exp.typed       = offer_typed;
        got_exp.typed_index = offer_want;
        pending_q.push_back(got_exp);
      end
      if (res.valid && res.ready) begin
        index_count <= index_count + 1;
        if (pending_q.size() == 0) begin
          $error("selected_index %0d arrived with nothing expected", res.selected_index);
          fail_count++;
        end else begin
          got_exp = pending_q.pop_front();
          if (res.selected_index !== got_exp.predicted) begin
            $error("selected_index: expected %0d, got %0d", got_exp.predicted,
                   res.selected_index);
            fail_count++;
          end
          if (got_exp.typed && res.selected_index !== got_exp.typed_index) begin
            $error("selected_index (table): expected %0d, got %0d", got_exp.typed_index,
                   res.selected_index);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int run;
    res.ready = 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long hold-off: the sender keeps offering, so the pipe fills
        res.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        res.ready = 1'b1;
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
        repeat (run) @(negedge clk);
        if ($urandom_range(0, 1) == 0) begin
          res.ready = 1'b0;
          // mostly short stalls, now and then a long one
          run = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
          repeat (run) @(negedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------------
  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      smp.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // offer one fraction and wait for its transfer; valid stays up afterwards
  task automatic offer_fraction(logic [RND_W-1:0] frac, bit typed, logic [IDX_W-1:0] want);
    smp.valid           = 1'b1;
    smp.random_fraction = frac;
    offer_typed         = typed;
    offer_want          = want;
    do @(posedge clk); while (!smp.ready);
    @(negedge clk);
  endtask

  // registers change only with the pipe drained
  task automatic write_register(lrsi_pkg::cfg_reg_t sel, logic [17:0] value);
    smp.valid = 1'b0;
    wait (pending_q.size() == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfgc.valid = 1'b1;
    cfgc.index = sel;
    cfgc.data  = value;
    do @(posedge clk); while (!cfgc.ready);
    @(negedge clk);
    cfgc.valid = 1'b0;
  endtask

  // biased fraction: extremes, near-halves, single-bit words and plain random words
  function automatic logic [RND_W-1:0] pick_fraction();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000 + $urandom_range(0, 4) - 2;
      3:       return 32'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed steps. Typed indices follow from the formula by hand:
  // eta 1 gives floor(P*u); eta 2 with P 2 crosses rank 1 at u = 0.75.
  // ---------------------------------------------------------------------------
  step_t directed_steps[] = '{
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h0000_0000, 1, 16'd0},  // reset: rank 0
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hFFFF_FFFF, 1, 16'd63}, // reset: top
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h8000_0000, 0, 16'd0},
    '{1, lrsi_pkg::REG_MAX_EXPECTED,    18'd65536,  32'h0,         0, 16'd0},
    '{1, lrsi_pkg::REG_POPULATION_SIZE, 18'd65535,  32'h0,         0, 16'd0},
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h8000_0000, 1, 16'd32767}, // P*u
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hFFFF_FFFF, 1, 16'd65534}, // sat.
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h0000_0000, 1, 16'd0},
    '{1, lrsi_pkg::REG_POPULATION_SIZE, 18'd2,      32'h0,         0, 16'd0},
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h8000_0000, 1, 16'd1},  // boundary
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h7FFF_FFFF, 1, 16'd0},
    '{1, lrsi_pkg::REG_MAX_EXPECTED,    18'd131072, 32'h0,         0, 16'd0},
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hC000_0000, 1, 16'd1},  // boundary
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hBFFF_FFFF, 1, 16'd0},
    '{1, lrsi_pkg::REG_MAX_EXPECTED,    18'h3FFFF,  32'h0,         0, 16'd0},  // eta > 2
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hC000_0000, 1, 16'd1},
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hBFFF_FFFF, 1, 16'd0},
    '{1, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h0,         0, 16'd0},  // eta < 1
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h8000_0000, 1, 16'd1},
    '{1, lrsi_pkg::REG_POPULATION_SIZE, 18'd0,      32'h0,         0, 16'd0},  // empty
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h1234_5678, 1, 16'd0},
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hFFFF_FFFF, 1, 16'd0},
    '{1, lrsi_pkg::REG_POPULATION_SIZE, 18'd1,      32'h0,         0, 16'd0},  // single
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'hFFFF_FFFF, 1, 16'd0},
    '{1, lrsi_pkg::REG_POPULATION_SIZE, 18'd1000,   32'h0,         0, 16'd0},
    '{1, lrsi_pkg::REG_MAX_EXPECTED,    18'd100000, 32'h0,         0, 16'd0},
    '{0, lrsi_pkg::REG_MAX_EXPECTED,    18'd0,      32'h5555_5555, 0, 16'd0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [17:0] eta_pick;
    logic [17:0] pop_pick;
    int          drain;
    rst                 = 1'b1;
    cycle_count         = 0;
    fail_count          = 0;
    index_count         = 0;
    write_count         = 0;
    hold_req            = 1'b0;
    eta_shadow          = lrsi_pkg::ETA_RESET;
    pop_shadow          = lrsi_pkg::POP_SIZE_RESET;
    offer_typed         = 1'b0;
    offer_want          = '0;
    smp.valid           = 1'b0;
    smp.random_fraction = '0;
    cfgc.valid          = 1'b0;
    cfgc.index          = lrsi_pkg::REG_MAX_EXPECTED;
    cfgc.data           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        write_register(directed_steps[i].reg_sel, directed_steps[i].wdata);
      end else begin
        idle_gap();
        offer_fraction(directed_steps[i].frac, directed_steps[i].typed,
                       directed_steps[i].want);
      end
    end

    // random phases: extremes first, then random settings, mostly small P
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin eta_pick = lrsi_pkg::ETA_TWO; pop_pick = 18'd65535; end
        1: begin eta_pick = lrsi_pkg::ETA_ONE; pop_pick = 18'd1;     end
        2: begin eta_pick = 18'h3FFFF;         pop_pick = 18'd3;     end
        3: begin eta_pick = 18'd0;             pop_pick = 18'd0;     end
        default: begin
          eta_pick = 18'($urandom_range(lrsi_pkg::ETA_ONE, lrsi_pkg::ETA_TWO));
          pop_pick = ($urandom_range(0, 2) == 0) ? 18'($urandom_range(1, 65535))
                                                 : 18'($urandom_range(1, 200));
        end
      endcase
      write_register(lrsi_pkg::REG_MAX_EXPECTED, eta_pick);
      write_register(lrsi_pkg::REG_POPULATION_SIZE, pop_pick);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4 && n == 20) hold_req = 1'b1;   // long receiver hold-off
        idle_gap();
        offer_fraction(pick_fraction(), 1'b0, '0);
      end
    end
    smp.valid = 1'b0;

    wait (pending_q.size() == 0);
    drain = 0;
    while (drain < 2 * LATENCY) begin
      @(posedge clk);
      drain++;
    end

    $display("covered %0d indices over %0d register writes, incl. eta clamping,",
             index_count, write_count);
    $display("empty/single/full populations and a %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("PASS linear_rank_selection_index");
    end else begin
      $display("FAIL linear_rank_selection_index");
    end
    $finish;
  end

endmodule
